// ===== design/tono_pkg.sv =====
package tono_pkg;

    localparam int OPTION_COUNT   = 256;
    localparam int OPT_W          = $clog2(OPTION_COUNT);
    localparam int OPT_STATE_W    = 2;
    localparam int MAX_NAME_BYTES = 8;
    localparam int NAME_IDX_W     = 3;
    localparam int APB_ADDR_W     = 6;
    localparam int APB_DATA_W     = 64;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_ZERO = 8'd0;
    localparam logic [7:0] TT_SEND = 8'd1;

    // Option numbers
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;

    // Input commands
    localparam logic [1:0] CMD_RX        = 2'd0;
    localparam logic [1:0] CMD_REQ_LOCAL = 2'd1;
    localparam logic [1:0] CMD_REQ_PEER  = 2'd2;

    // Echo change codes
    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_ON   = 2'd1;
    localparam logic [1:0] ECHO_OFF  = 2'd2;

    // Status codes
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_UNEXPECTED = 3'd1;
    localparam logic [2:0] STS_ALREADY_ON = 3'd2;
    localparam logic [2:0] STS_PENDING    = 3'd3;
    localparam logic [2:0] STS_BAD_CODE   = 3'd4;
    localparam logic [2:0] STS_UNK_SUBNEG = 3'd5;
    localparam logic [2:0] STS_MALFORMED  = 3'd6;

    // Register indexes on the APB port
    localparam logic [2:0] REG_LOCAL_ECHO  = 3'd0;
    localparam logic [2:0] REG_PASSTHROUGH = 3'd1;
    localparam logic [2:0] REG_COLUMNS     = 3'd2;
    localparam logic [2:0] REG_LINES       = 3'd3;
    localparam logic [2:0] REG_NAME        = 3'd4;
    localparam logic [2:0] REG_NAME_LEN    = 3'd5;

    typedef enum logic [1:0] {
        ST_NO      = 2'd0,
        ST_YES     = 2'd1,
        ST_WANTNO  = 2'd2,
        ST_WANTYES = 2'd3
    } opt_state_t;

    typedef enum logic [1:0] {
        DEST_TERM = 2'd0,
        DEST_NET  = 2'd1,
        DEST_NONE = 2'd2
    } dest_t;

    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_IAC   = 2'd1,
        PH_OPT   = 2'd2,
        PH_TTYPE = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        EV_NONE,
        EV_DATA,
        EV_STATUS,
        EV_WILL,
        EV_WONT,
        EV_DO,
        EV_DONT,
        EV_REQ_LOCAL,
        EV_REQ_PEER,
        EV_TTYPE
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t   kind;
        logic [7:0] value;
        logic [2:0] status;
        logic       malformed;
    } event_t;

    typedef struct packed {
        logic       single;
        dest_t      dest;
        logic [7:0] value;
        logic       send3;
        logic [7:0] code;
        logic [7:0] opt;
        logic       naws;
        logic       ttype;
        logic [1:0] echo;
        logic [2:0] status;
    } job_t;

    typedef struct packed {
        logic        local_echo;
        logic        passthrough;
        logic [7:0]  columns;
        logic [7:0]  lines;
        logic [63:0] name;
        logic [3:0]  name_len;
    } cfg_t;

    typedef enum logic [4:0] {
        E_IDLE,
        E_SINGLE,
        E_S3_IAC,
        E_S3_CODE,
        E_S3_OPT,
        E_SB_IAC,
        E_SB_SB,
        E_SB_OPT,
        E_SB_ZERO,
        E_NAWS_COL,
        E_NAWS_COLX,
        E_NAWS_ZERO,
        E_NAWS_LIN,
        E_NAWS_LINX,
        E_TT_NAME,
        E_END_IAC,
        E_END_SE
    } emit_t;

    // Terminal type sent when no name is configured
    function automatic logic [7:0] unknown_char(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h55;
            3'd1:    c = 8'h4E;
            3'd2:    c = 8'h4B;
            3'd3:    c = 8'h4E;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h57;
            3'd6:    c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/tono_ram.sv =====
module tono_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tono_parser.sv =====
module tono_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [1:0]             command,
    input  logic [7:0]             data_byte,
    input  logic                   passthrough,
    output tono_pkg::event_t       ev
);
    import tono_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_code_reg, held_code_next;
    logic [1:0] subneg_count_reg, subneg_count_next;

    logic [1:0] tail_k;
    logic [7:0] tail_expect;
    logic       tail_mismatch;
    logic       rx_parse;

    assign rx_parse      = (command == CMD_RX) && !passthrough;
    assign tail_k        = (subneg_count_reg == 2'd3) ? 2'd2 : subneg_count_reg;
    assign tail_mismatch = (data_byte != tail_expect);

    always_comb begin
        case (tail_k)
            2'd0:    tail_expect = TT_SEND;
            2'd1:    tail_expect = B_IAC;
            default: tail_expect = B_SE;
        endcase
    end

    // Next parser state
    always_comb begin
        phase_next        = phase_reg;
        held_code_next    = held_code_reg;
        subneg_count_next = subneg_count_reg;
        if (rx_parse) begin
            case (phase_reg)
                PH_DATA: begin
                    if (data_byte == B_IAC) begin
                        phase_next = PH_IAC;
                    end
                end
                PH_IAC: begin
                    if (data_byte == B_IAC) begin
                        phase_next = PH_DATA;
                    end else begin
                        held_code_next = data_byte;
                        phase_next     = PH_OPT;
                    end
                end
                PH_OPT: begin
                    phase_next = PH_DATA;
                    if (held_code_reg == B_SB && data_byte == OPT_TTYPE) begin
                        phase_next        = PH_TTYPE;
                        held_code_next    = '0;
                        subneg_count_next = '0;
                    end
                end
                PH_TTYPE: begin
                    if (tail_k == 2'd2) begin
                        phase_next        = PH_DATA;
                        held_code_next    = '0;
                        subneg_count_next = '0;
                    end else begin
                        held_code_next    = {held_code_reg[7:1],
                                             held_code_reg[0] | tail_mismatch};
                        subneg_count_next = tail_k + 2'd1;
                    end
                end
                default: phase_next = PH_DATA;
            endcase
        end
    end

    // Event handed to the update stage
    always_comb begin
        ev.kind      = EV_NONE;
        ev.value     = data_byte;
        ev.status    = STS_OK;
        ev.malformed = 1'b0;
        case (command)
            CMD_RX: begin
                if (passthrough) begin
                    ev.kind = EV_DATA;
                end else begin
                    case (phase_reg)
                        PH_DATA: begin
                            if (data_byte != B_IAC) begin
                                ev.kind = EV_DATA;
                            end
                        end
                        PH_IAC: begin
                            if (data_byte == B_IAC) begin
                                ev.kind = EV_DATA;
                            end
                        end
                        PH_OPT: begin
                            case (held_code_reg)
                                B_WILL: ev.kind = EV_WILL;
                                B_WONT: ev.kind = EV_WONT;
                                B_DO:   ev.kind = EV_DO;
                                B_DONT: ev.kind = EV_DONT;
                                B_SB: begin
                                    if (data_byte != OPT_TTYPE) begin
                                        ev.kind   = EV_STATUS;
                                        ev.status = STS_UNK_SUBNEG;
                                    end
                                end
                                default: begin
                                    ev.kind   = EV_STATUS;
                                    ev.status = STS_BAD_CODE;
                                end
                            endcase
                        end
                        PH_TTYPE: begin
                            if (tail_k == 2'd2) begin
                                ev.kind      = EV_TTYPE;
                                ev.malformed = held_code_reg[0] | tail_mismatch;
                            end
                        end
                        default: ev.kind = EV_NONE;
                    endcase
                end
            end
            CMD_REQ_LOCAL: ev.kind = EV_REQ_LOCAL;
            CMD_REQ_PEER:  ev.kind = EV_REQ_PEER;
            default:       ev.kind = EV_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_DATA;
            held_code_reg    <= '0;
            subneg_count_reg <= '0;
        end else if (accept) begin
            phase_reg        <= phase_next;
            held_code_reg    <= held_code_next;
            subneg_count_reg <= subneg_count_next;
        end
    end

endmodule

// ===== design/tono_update.sv =====
module tono_update (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_accept,
    input  tono_pkg::event_t                 in_event,
    output logic                             in_ready,
    input  logic                             local_echo,
    input  logic [tono_pkg::OPT_STATE_W-1:0] peer_rdata,
    input  logic [tono_pkg::OPT_STATE_W-1:0] local_rdata,
    output logic                             peer_we,
    output logic                             local_we,
    output logic [tono_pkg::OPT_W-1:0]       wr_addr,
    output logic [tono_pkg::OPT_STATE_W-1:0] wr_data,
    output logic                             job_valid,
    output tono_pkg::job_t                   job,
    input  logic                             job_ready
);
    import tono_pkg::*;

    logic             s1_valid_reg;
    event_t           ev_reg;
    logic             clear_reg;
    logic [OPT_W-1:0] clear_idx_reg;
    logic             byp_peer_reg;
    logic             byp_local_reg;
    opt_state_t       byp_data_reg;

    opt_state_t peer_cur, local_cur, new_state;
    logic       wr_peer_c, wr_local_c;
    logic       job_valid_c, adv;
    logic       peer_may, we_may;
    logic [7:0] opt;
    job_t       job_c;

    assign opt = ev_reg.value;

    // Forwarded value wins over the RAM
    always_comb begin
        if (byp_peer_reg) begin
            peer_cur = byp_data_reg;
        end else begin
            peer_cur = opt_state_t'(peer_rdata);
        end
        if (byp_local_reg) begin
            local_cur = byp_data_reg;
        end else begin
            local_cur = opt_state_t'(local_rdata);
        end
    end

    assign peer_may = (opt == OPT_ECHO) ? !local_echo : (opt == OPT_SGA);
    assign we_may   = (opt == OPT_ECHO) ? local_echo :
                      (opt == OPT_SGA || opt == OPT_TTYPE || opt == OPT_NAWS);

    always_comb begin
        job_c      = '0;
        job_c.dest = DEST_NET;
        job_c.opt  = opt;
        new_state  = ST_NO;
        wr_peer_c  = 1'b0;
        wr_local_c = 1'b0;
        case (ev_reg.kind)
            EV_DATA: begin
                job_c.single = 1'b1;
                job_c.dest   = DEST_TERM;
                job_c.value  = ev_reg.value;
            end
            EV_STATUS: job_c.status = ev_reg.status;
            EV_TTYPE: begin
                job_c.ttype  = 1'b1;
                job_c.status = ev_reg.malformed ? STS_MALFORMED : STS_OK;
            end
            EV_WILL: begin
                wr_peer_c = 1'b1;
                new_state = peer_cur;
                case (peer_cur)
                    ST_NO: begin
                        job_c.send3 = 1'b1;
                        if (peer_may) begin
                            new_state  = ST_YES;
                            job_c.code = B_DO;
                        end else begin
                            job_c.code = B_DONT;
                        end
                    end
                    ST_WANTNO: begin
                        new_state    = ST_NO;
                        job_c.status = STS_UNEXPECTED;
                    end
                    ST_WANTYES: new_state = ST_YES;
                    default:    new_state = peer_cur;
                endcase
            end
            EV_WONT: begin
                wr_peer_c = 1'b1;
                new_state = ST_NO;
                if (peer_cur == ST_YES) begin
                    job_c.send3 = 1'b1;
                    job_c.code  = B_DONT;
                end
            end
            EV_DO: begin
                wr_local_c = 1'b1;
                new_state  = local_cur;
                case (local_cur)
                    ST_NO: begin
                        job_c.send3 = 1'b1;
                        if (we_may) begin
                            new_state  = ST_YES;
                            job_c.code = B_WILL;
                            job_c.echo = (opt == OPT_ECHO) ? ECHO_ON : ECHO_NONE;
                            job_c.naws = (opt == OPT_NAWS);
                        end else begin
                            job_c.code = B_WONT;
                        end
                    end
                    ST_WANTNO: begin
                        new_state    = ST_NO;
                        job_c.status = STS_UNEXPECTED;
                    end
                    ST_WANTYES: begin
                        new_state  = ST_YES;
                        job_c.echo = (opt == OPT_ECHO) ? ECHO_ON : ECHO_NONE;
                        job_c.naws = (opt == OPT_NAWS);
                    end
                    default: new_state = local_cur;
                endcase
            end
            EV_DONT: begin
                wr_local_c = 1'b1;
                new_state  = ST_NO;
                if (local_cur == ST_YES) begin
                    job_c.send3 = 1'b1;
                    job_c.code  = B_WONT;
                    job_c.echo  = (opt == OPT_ECHO) ? ECHO_OFF : ECHO_NONE;
                end
            end
            EV_REQ_LOCAL: begin
                wr_local_c = 1'b1;
                new_state  = local_cur;
                if (local_cur == ST_NO) begin
                    new_state   = ST_WANTYES;
                    job_c.send3 = 1'b1;
                    job_c.code  = B_WILL;
                end else if (local_cur == ST_YES) begin
                    job_c.status = STS_ALREADY_ON;
                end else begin
                    job_c.status = STS_PENDING;
                end
            end
            EV_REQ_PEER: begin
                wr_peer_c = 1'b1;
                new_state = peer_cur;
                if (peer_cur == ST_NO) begin
                    new_state   = ST_WANTYES;
                    job_c.send3 = 1'b1;
                    job_c.code  = B_DO;
                end else if (peer_cur == ST_YES) begin
                    job_c.status = STS_ALREADY_ON;
                end else begin
                    job_c.status = STS_PENDING;
                end
            end
            default: job_c = '0;
        endcase
        // Report-only beat when nothing else goes out
        if (!job_c.single && !job_c.send3 && !job_c.naws && !job_c.ttype &&
            (job_c.status != STS_OK || job_c.echo != ECHO_NONE)) begin
            job_c.single = 1'b1;
            job_c.dest   = DEST_NONE;
            job_c.value  = '0;
        end
        job_valid_c = job_c.single | job_c.send3 | job_c.naws | job_c.ttype;
    end

    // While clearing after reset, write NO into every entry and hold the input
    assign adv       = s1_valid_reg && (!job_valid_c || job_ready);
    assign in_ready  = !clear_reg && (!s1_valid_reg || adv);
    assign job_valid = s1_valid_reg && job_valid_c;
    assign job       = job_c;
    assign peer_we   = clear_reg || (adv && wr_peer_c);
    assign local_we  = clear_reg || (adv && wr_local_c);
    assign wr_addr   = clear_reg ? clear_idx_reg : opt;
    assign wr_data   = clear_reg ? ST_NO : new_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            clear_reg     <= 1'b1;
            clear_idx_reg <= '0;
            byp_peer_reg  <= 1'b0;
            byp_local_reg <= 1'b0;
        end else begin
            if (clear_reg) begin
                clear_idx_reg <= clear_idx_reg + OPT_W'(1);
                if (clear_idx_reg == OPT_W'(OPTION_COUNT - 1)) begin
                    clear_reg <= 1'b0;
                end
            end
            if (in_accept) begin
                s1_valid_reg  <= 1'b1;
                byp_peer_reg  <= peer_we && (wr_addr == in_event.value);
                byp_local_reg <= local_we && (wr_addr == in_event.value);
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ev_reg       <= in_event;
            byp_data_reg <= new_state;
        end
    end

endmodule

// ===== design/tono_emitter.sv =====
module tono_emitter #(
    parameter int MAX_NAME_BYTES = tono_pkg::MAX_NAME_BYTES
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    input  tono_pkg::job_t  job,
    output logic            job_ready,
    input  tono_pkg::cfg_t  cfg,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_destination,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_echo_change,
    output logic [2:0]      m_status,
    output logic            m_last
);
    import tono_pkg::*;

    emit_t                 state_reg, state_next, beat_next, first_state;
    job_t                  job_reg;
    logic [NAME_IDX_W-1:0] name_idx_reg;

    logic [3:0] name_count;
    logic       name_last;
    logic       last;
    logic [7:0] name_byte;

    always_comb begin
        if (cfg.name_len == 4'd0) begin
            name_count = 4'd7;
        end else if (cfg.name_len > 4'(MAX_NAME_BYTES)) begin
            name_count = 4'(MAX_NAME_BYTES);
        end else begin
            name_count = cfg.name_len;
        end
    end

    assign name_last = ({1'b0, name_idx_reg} == (name_count - 4'd1));
    assign name_byte = (cfg.name_len == 4'd0) ? unknown_char(name_idx_reg) :
                       cfg.name[8*name_idx_reg +: 8];

    always_comb begin
        if (job.single) begin
            first_state = E_SINGLE;
        end else if (job.send3) begin
            first_state = E_S3_IAC;
        end else begin
            first_state = E_SB_IAC;
        end
    end

    // Successor of the beat on show
    always_comb begin
        case (state_reg)
            E_S3_IAC:    beat_next = E_S3_CODE;
            E_S3_CODE:   beat_next = E_S3_OPT;
            E_S3_OPT:    beat_next = job_reg.naws ? E_SB_IAC : E_IDLE;
            E_SB_IAC:    beat_next = E_SB_SB;
            E_SB_SB:     beat_next = E_SB_OPT;
            E_SB_OPT:    beat_next = E_SB_ZERO;
            E_SB_ZERO:   beat_next = job_reg.naws ? E_NAWS_COL : E_TT_NAME;
            E_NAWS_COL:  beat_next = (cfg.columns == B_IAC) ? E_NAWS_COLX : E_NAWS_ZERO;
            E_NAWS_COLX: beat_next = E_NAWS_ZERO;
            E_NAWS_ZERO: beat_next = E_NAWS_LIN;
            E_NAWS_LIN:  beat_next = (cfg.lines == B_IAC) ? E_NAWS_LINX : E_END_IAC;
            E_NAWS_LINX: beat_next = E_END_IAC;
            E_TT_NAME:   beat_next = name_last ? E_END_IAC : E_TT_NAME;
            E_END_IAC:   beat_next = E_END_SE;
            default:     beat_next = E_IDLE;
        endcase
    end

    assign last      = (state_reg != E_IDLE) && (beat_next == E_IDLE);
    assign job_ready = (state_reg == E_IDLE) || (m_ready && last);

    always_comb begin
        if (job_ready) begin
            state_next = job_valid ? first_state : E_IDLE;
        end else if (m_ready) begin
            state_next = beat_next;
        end else begin
            state_next = state_reg;
        end
    end

    // Beat contents
    always_comb begin
        m_valid       = (state_reg != E_IDLE);
        m_destination = DEST_NET;
        m_echo_change = last ? job_reg.echo : ECHO_NONE;
        m_status      = last ? job_reg.status : STS_OK;
        m_last        = last;
        case (state_reg)
            E_IDLE: begin
                m_destination = DEST_TERM;
                m_out_byte    = B_ZERO;
            end
            E_SINGLE: begin
                m_destination = job_reg.dest;
                m_out_byte    = job_reg.value;
            end
            E_S3_IAC:    m_out_byte = B_IAC;
            E_S3_CODE:   m_out_byte = job_reg.code;
            E_S3_OPT:    m_out_byte = job_reg.opt;
            E_SB_IAC:    m_out_byte = B_IAC;
            E_SB_SB:     m_out_byte = B_SB;
            E_SB_OPT:    m_out_byte = job_reg.naws ? OPT_NAWS : OPT_TTYPE;
            E_SB_ZERO:   m_out_byte = B_ZERO;
            E_NAWS_COL:  m_out_byte = cfg.columns;
            E_NAWS_COLX: m_out_byte = B_IAC;
            E_NAWS_ZERO: m_out_byte = B_ZERO;
            E_NAWS_LIN:  m_out_byte = cfg.lines;
            E_NAWS_LINX: m_out_byte = B_IAC;
            E_TT_NAME:   m_out_byte = name_byte;
            E_END_IAC:   m_out_byte = B_IAC;
            E_END_SE:    m_out_byte = B_SE;
            default:     m_out_byte = B_ZERO;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= E_IDLE;
            name_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (job_ready) begin
                name_idx_reg <= '0;
            end else if (state_reg == E_TT_NAME && m_ready && !name_last) begin
                name_idx_reg <= name_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            job_reg <= job;
        end
    end

endmodule

// ===== design/telnet_option_negotiator.sv =====
// Telnet option negotiator, client side.
//
// Input channel (s_*): one beat per received network byte (command 0) or
// per local request to enable our option (1) or the peer's option (2).
// Result channel (m_*): zero or more beats per input beat, in order; the
// final beat of an input carries m_last, the echo change and the status.
// Data bytes go to the terminal, negotiation replies go to the network.
// APB port: six registers at 8-byte strides; write only while idle.
//
// Flow: the beat is parsed and the RAM read registered; the state update
// then passes the reply to the emitter, which registers and shows it.
// Ordinary data sustains one beat per cycle while m_ready is high. A reply
// burst of n beats (up to 14) holds the input until its last beat is
// taken; the per-option state RAMs are read, updated and written back once
// per input beat, with a forward path for back-to-back hits.
// Reset: a clearing pass writes NO into all 256 option entries, one per
// cycle, with s_ready low until the pass ends; the parser restarts in
// plain data; registers take their reset values.
// Stall: when m_ready drops the current beat holds, the update stage
// fills and s_ready falls; nothing is lost or repeated.
module telnet_option_negotiator #(
    parameter int MAX_NAME_BYTES = tono_pkg::MAX_NAME_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [7:0]                      s_data_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_destination,
    output logic [7:0]                      m_out_byte,
    output logic [1:0]                      m_echo_change,
    output logic [2:0]                      m_status,
    output logic                            m_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tono_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tono_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tono_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tono_pkg::*;

    // Configuration registers
    logic        local_echo_reg;
    logic        passthrough_reg;
    logic [7:0]  columns_reg;
    logic [7:0]  lines_reg;
    logic [63:0] name_reg;
    logic [3:0]  name_len_reg;
    cfg_t        cfg;

    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic                   s_accept;
    event_t                 ev;
    logic                   peer_we, local_we;
    logic [OPT_W-1:0]       wr_addr;
    logic [OPT_STATE_W-1:0] wr_data;
    logic [OPT_STATE_W-1:0] peer_rdata, local_rdata;
    logic                   job_valid, job_ready;
    job_t                   job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_echo_reg  <= 1'b0;
            passthrough_reg <= 1'b0;
            columns_reg     <= 8'd80;
            lines_reg       <= 8'd24;
            name_reg        <= '0;
            name_len_reg    <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LOCAL_ECHO:  local_echo_reg  <= pwdata[0];
                REG_PASSTHROUGH: passthrough_reg <= pwdata[0];
                REG_COLUMNS:     columns_reg     <= pwdata[7:0];
                REG_LINES:       lines_reg       <= pwdata[7:0];
                REG_NAME:        name_reg        <= pwdata[63:0];
                REG_NAME_LEN:    name_len_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read back, zero-extended
    always_comb begin
        case (reg_idx)
            REG_LOCAL_ECHO:  prdata = {63'd0, local_echo_reg};
            REG_PASSTHROUGH: prdata = {63'd0, passthrough_reg};
            REG_COLUMNS:     prdata = {56'd0, columns_reg};
            REG_LINES:       prdata = {56'd0, lines_reg};
            REG_NAME:        prdata = name_reg;
            REG_NAME_LEN:    prdata = {60'd0, name_len_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.local_echo  = local_echo_reg;
    assign cfg.passthrough = passthrough_reg;
    assign cfg.columns     = columns_reg;
    assign cfg.lines       = lines_reg;
    assign cfg.name        = name_reg;
    assign cfg.name_len    = name_len_reg;

    assign s_accept = s_valid && s_ready;

    // Stage 0: parse the beat and launch the RAM reads
    tono_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .command     (s_command),
        .data_byte   (s_data_byte),
        .passthrough (passthrough_reg),
        .ev          (ev)
    );

    tono_ram #(
        .WIDTH (OPT_STATE_W),
        .DEPTH (OPTION_COUNT)
    ) u_peer_ram (
        .clk   (aclk),
        .we    (peer_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (s_accept),
        .raddr (s_data_byte),
        .rdata (peer_rdata)
    );

    tono_ram #(
        .WIDTH (OPT_STATE_W),
        .DEPTH (OPTION_COUNT)
    ) u_local_ram (
        .clk   (aclk),
        .we    (local_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (s_accept),
        .raddr (s_data_byte),
        .rdata (local_rdata)
    );

    // Stage 1: modify the option state, write it back, build the reply
    tono_update u_update (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_accept),
        .in_event    (ev),
        .in_ready    (s_ready),
        .local_echo  (local_echo_reg),
        .peer_rdata  (peer_rdata),
        .local_rdata (local_rdata),
        .peer_we     (peer_we),
        .local_we    (local_we),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .job_valid   (job_valid),
        .job         (job),
        .job_ready   (job_ready)
    );

    // Output: play the reply out one beat at a time
    tono_emitter #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .job           (job),
        .job_ready     (job_ready),
        .cfg           (cfg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_destination (m_destination),
        .m_out_byte    (m_out_byte),
        .m_echo_change (m_echo_change),
        .m_status      (m_status),
        .m_last        (m_last)
    );

endmodule

// ===== design/tono_checker.sv =====
module tono_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_destination,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_echo_change,
    input logic [2:0] m_status,
    input logic       m_last
);
    import tono_pkg::*;

    // Hold a stalled beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
        $stable(m_destination) && $stable(m_last))
        else $error("stalled result beat changed");

    // A report-only beat closes its item and carries something to report
    a_report_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_destination == DEST_NONE |->
        m_last && m_out_byte == B_ZERO && (m_status != STS_OK || m_echo_change != ECHO_NONE))
        else $error("report-only beat malformed");

    // Status and echo change ride on the closing beat only
    a_tail_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == STS_OK && m_echo_change == ECHO_NONE)
        else $error("status on a non-final beat");

    // A terminal byte is always a single-beat result
    a_term_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_destination == DEST_TERM |-> m_last && m_status == STS_OK)
        else $error("terminal byte inside a burst");

endmodule

bind telnet_option_negotiator tono_checker u_tono_checker (.*);
